[rtl/core/ple_pkg.sv]
`timescale 1ns / 1ps
package ple_pkg;

   localparam int PLE_CAPACITY   = 256;
   localparam int PLE_DATA_WIDTH = 32;
   localparam int ACT_W  = 3;
   localparam int POS_W  = 9;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_INS_FRONT = 3'd0,
      ACT_INS_BACK  = 3'd1,
      ACT_INS_AFTER = 3'd2,
      ACT_RM_FRONT  = 3'd3,
      ACT_RM_BACK   = 3'd4,
      ACT_RM_POS    = 3'd5,
      ACT_READ      = 3'd6,
      ACT_WRITE     = 3'd7
   } ple_action_type;

   localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC,
      S_ALLOC_WAIT,
      S_WALK_ISSUE,
      S_WALK,
      S_RD_ISSUE,
      S_RD_WAIT,
      S_LINK_A,
      S_LINK_B,
      S_REPLY,
      S_REPLY_MISS,
      S_REPLY_FULL
   } ple_state_type;

   typedef struct packed {
      logic                latch;
      logic                walk_start;
      logic                walk_step;
      logic                alloc;
      logic                alloc_take;
      logic                rd_take;
      logic                link_a;
      logic                link_b;
      logic                reply;
      logic [STAT_W-1:0]   reply_status;
   } ple_cmd_type;

   typedef struct packed {
      ple_action_type act;
      logic           full;
      logic           empty;
      logic           pos_gt;
      logic           walk_mode;
      logic           k_zero;
      logic           k_one;
   } ple_stat_type;

endpackage

[rtl/core/ple_ram.sv]
`timescale 1ns / 1ps
module ple_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            we,
   input  logic [$clog2(DEPTH)-1:0]        waddr,
   input  logic [WIDTH-1:0]                wdata,
   input  logic [$clog2(DEPTH)-1:0]        raddr,
   output logic [WIDTH-1:0]                rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/ple_ctrl.sv]
`timescale 1ns / 1ps
module ple_ctrl import ple_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ple_stat_type stat,
   output ple_cmd_type  cmd
);

   ple_state_type state_ff, state_in, after_walk;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      after_walk = (stat.act == ACT_WRITE) ? S_LINK_A : S_RD_ISSUE;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (stat.act)
               ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AFTER:
                  state_in = stat.full ? S_REPLY_FULL : S_ALLOC;
               ACT_RM_FRONT, ACT_RM_BACK:
                  state_in = stat.empty ? S_REPLY_MISS : S_WALK_ISSUE;
               default:
                  state_in = stat.pos_gt ? S_REPLY_MISS : S_WALK_ISSUE;
            endcase
         end
         S_ALLOC:      state_in = S_ALLOC_WAIT;
         S_ALLOC_WAIT: state_in = stat.walk_mode ? S_WALK_ISSUE : S_LINK_A;
         S_WALK_ISSUE: state_in = stat.k_zero ? after_walk : S_WALK;
         S_WALK: begin
            if (stat.k_one) state_in = after_walk;
         end
         S_RD_ISSUE:   state_in = S_RD_WAIT;
         S_RD_WAIT:    state_in = (stat.act == ACT_READ) ? S_REPLY : S_LINK_A;
         S_LINK_A: begin
            state_in = (stat.act == ACT_INS_AFTER && stat.walk_mode) ? S_LINK_B : S_REPLY;
         end
         S_LINK_B:     state_in = S_REPLY;
         S_REPLY, S_REPLY_MISS, S_REPLY_FULL: state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            cmd.latch = start;
         end
         S_DECODE:     cmd.walk_start = 1'b1;
         S_ALLOC:      cmd.alloc = 1'b1;
         S_ALLOC_WAIT: cmd.alloc_take = 1'b1;
         S_WALK:       cmd.walk_step = 1'b1;
         S_RD_WAIT:    cmd.rd_take = 1'b1;
         S_LINK_A:     cmd.link_a = 1'b1;
         S_LINK_B:     cmd.link_b = 1'b1;
         S_REPLY: begin
            cmd.reply = 1'b1;
            cmd.reply_status = ST_DONE;
         end
         S_REPLY_MISS: begin
            cmd.reply = 1'b1;
            cmd.reply_status = ST_MISS;
         end
         S_REPLY_FULL: begin
            cmd.reply = 1'b1;
            cmd.reply_status = ST_FULL;
         end
         default: ;
      endcase
   end

endmodule

[rtl/core/ple_dpath.sv]
`timescale 1ns / 1ps
module ple_dpath import ple_pkg::*; #(
   parameter int CAPACITY   = PLE_CAPACITY,
   parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [POS_W-1:0]  req_position,
   input  logic [VAL_W-1:0]  req_value,
   input  ple_cmd_type       cmd,
   output ple_stat_type      stat,
   output logic              rsp_strobe,
   output logic [VAL_W-1:0]  rsp_read_value,
   output logic [STAT_W-1:0] rsp_status,
   output logic [POS_W-1:0]  rsp_item_count
);

   localparam int SW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   ple_action_type        act_ff, act_in;
   logic [POS_W-1:0]      pos_ff, pos_in, k_ff, k_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in, rd_ff, rd_in;
   logic [SW-1:0]         cur_ff, cur_in, n_ff, n_in;
   logic [SW-1:0]         nb_next_ff, nb_next_in, nb_prev_ff, nb_prev_in;
   logic [SW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic                  pop_ff, pop_in;
   logic [CW-1:0]         count_ff, count_in, fsp_ff, fsp_in, fresh_ff, fresh_in;
   logic                  strobe_ff, strobe_in;
   logic [VAL_W-1:0]      rval_ff, rval_in;
   logic [STAT_W-1:0]     rstat_ff, rstat_in;
   logic [POS_W-1:0]      rcount_ff, rcount_in;

   logic [CMPW-1:0]       pos_x, cnt_x;
   logic                  pos_one, pos_eq, pos_ge, front_mode, tail_mode, walk_mode;
   logic                  is_ins, is_rm;

   logic                  data_we, next_we, prev_we, free_we;
   logic [SW-1:0]         data_wa, next_wa, prev_wa, free_wa;
   logic [SW-1:0]         next_ra, free_ra;
   logic [DATA_WIDTH-1:0] data_wd, data_rd;
   logic [SW-1:0]         next_wd, prev_wd, free_wd, next_rd, prev_rd, free_rd;
   logic [CW-1:0]         fsp_dec;

   ple_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data (
      .clock(clock), .we(data_we), .waddr(data_wa), .wdata(data_wd),
      .raddr(cur_ff), .rdata(data_rd));
   ple_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .raddr(next_ra), .rdata(next_rd));
   ple_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
      .raddr(cur_ff), .rdata(prev_rd));
   ple_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
      .clock(clock), .we(free_we), .waddr(free_wa), .wdata(free_wd),
      .raddr(free_ra), .rdata(free_rd));

   always_comb begin
      pos_x   = CMPW'(pos_ff);
      cnt_x   = CMPW'(count_ff);
      pos_one = (pos_ff == POS_W'(1));
      pos_eq  = (pos_x == cnt_x);
      pos_ge  = (pos_x >= cnt_x);
      is_ins  = (act_ff == ACT_INS_FRONT) || (act_ff == ACT_INS_BACK) ||
                (act_ff == ACT_INS_AFTER);
      is_rm   = (act_ff == ACT_RM_FRONT) || (act_ff == ACT_RM_BACK) ||
                (act_ff == ACT_RM_POS);
      front_mode = (act_ff == ACT_INS_FRONT) || (act_ff == ACT_RM_FRONT) ||
                   (act_ff == ACT_RM_POS && pos_one);
      tail_mode  = (act_ff == ACT_INS_BACK) || (act_ff == ACT_RM_BACK) ||
                   (act_ff == ACT_RM_POS && pos_eq && !pos_one) ||
                   (act_ff == ACT_INS_AFTER && pos_ge);
      walk_mode  = !front_mode && !tail_mode;

      stat.act       = act_ff;
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.empty     = (count_ff == '0);
      stat.pos_gt    = (pos_x > cnt_x);
      stat.walk_mode = walk_mode;
      stat.k_zero    = (k_ff == '0);
      stat.k_one     = (k_ff == POS_W'(1));

      fsp_dec = fsp_ff - CW'(1);
      // chase the link as soon as it lands
      next_ra = cmd.walk_step ? next_rd : cur_ff;
      free_ra = fsp_dec[SW-1:0];
   end

   // memory writes
   always_comb begin
      data_we = 1'b0; data_wa = cur_ff; data_wd = val_ff;
      next_we = 1'b0; next_wa = n_ff;   next_wd = head_ff;
      prev_we = 1'b0; prev_wa = n_ff;   prev_wd = tail_ff;
      free_we = 1'b0; free_wa = fsp_ff[SW-1:0]; free_wd = cur_ff;
      if (cmd.link_a) begin
         if (act_ff == ACT_WRITE) begin
            data_we = 1'b1;
         end else if (is_ins) begin
            data_we = 1'b1;
            data_wa = n_ff;
            if (front_mode) begin
               next_we = 1'b1;
               prev_we = (count_ff != '0);
               prev_wa = head_ff;
               prev_wd = n_ff;
            end else if (tail_mode) begin
               prev_we = 1'b1;
               next_we = (count_ff != '0);
               next_wa = tail_ff;
               next_wd = n_ff;
            end else begin
               next_we = 1'b1;
               next_wd = nb_next_ff;
               prev_we = 1'b1;
               prev_wd = cur_ff;
            end
         end else if (is_rm) begin
            free_we = 1'b1;
            if (walk_mode) begin
               next_we = 1'b1;
               next_wa = nb_prev_ff;
               next_wd = nb_next_ff;
               prev_we = 1'b1;
               prev_wa = nb_next_ff;
               prev_wd = nb_prev_ff;
            end
         end
      end
      if (cmd.link_b) begin
         prev_we = 1'b1;
         prev_wa = nb_next_ff;
         prev_wd = n_ff;
         next_we = 1'b1;
         next_wa = cur_ff;
         next_wd = n_ff;
      end
   end

   always_comb begin
      act_in = act_ff; pos_in = pos_ff; val_in = val_ff; rd_in = rd_ff;
      cur_in = cur_ff; k_in = k_ff; n_in = n_ff; pop_in = pop_ff;
      nb_next_in = nb_next_ff; nb_prev_in = nb_prev_ff;
      head_in = head_ff; tail_in = tail_ff; count_in = count_ff;
      fsp_in = fsp_ff; fresh_in = fresh_ff;
      strobe_in = cmd.reply;
      rval_in = rval_ff; rstat_in = rstat_ff; rcount_in = rcount_ff;

      if (cmd.latch) begin
         act_in = ple_action_type'(req_action);
         pos_in = (req_position == '0) ? POS_W'(1) : req_position;
         val_in = DATA_WIDTH'(req_value);
         rd_in  = '0;
      end
      if (cmd.walk_start) begin
         cur_in = tail_mode ? tail_ff : head_ff;
         k_in   = walk_mode ? (pos_ff - POS_W'(1)) : '0;
      end
      if (cmd.walk_step) begin
         cur_in = next_rd;
         k_in   = k_ff - POS_W'(1);
      end
      if (cmd.alloc) begin
         pop_in = (fsp_ff != '0);
         if (fsp_ff != '0) begin
            fsp_in = fsp_dec;
         end else begin
            n_in     = fresh_ff[SW-1:0];
            fresh_in = fresh_ff + CW'(1);
         end
      end
      if (cmd.alloc_take && pop_ff) begin
         n_in = free_rd;
      end
      if (cmd.rd_take) begin
         rd_in      = data_rd;
         nb_next_in = next_rd;
         nb_prev_in = prev_rd;
      end
      if (cmd.link_a) begin
         if (is_ins) begin
            count_in = count_ff + CW'(1);
            if (front_mode) begin
               head_in = n_ff;
               if (count_ff == '0) tail_in = n_ff;
            end else if (tail_mode) begin
               tail_in = n_ff;
               if (count_ff == '0) head_in = n_ff;
            end
         end else if (is_rm) begin
            count_in = count_ff - CW'(1);
            fsp_in   = fsp_ff + CW'(1);
            if (front_mode) head_in = nb_next_ff;
            else if (tail_mode) tail_in = nb_prev_ff;
            if (count_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
         end
      end
      if (cmd.reply) begin
         // only a read returns the stored word
         rval_in   = (cmd.reply_status == ST_DONE && act_ff == ACT_READ) ?
                     VAL_W'(rd_ff) : '0;
         rstat_in  = cmd.reply_status;
         rcount_in = POS_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         fsp_ff    <= '0;
         fresh_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         fsp_ff    <= fsp_in;
         fresh_ff  <= fresh_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      rd_ff      <= rd_in;
      cur_ff     <= cur_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      pop_ff     <= pop_in;
      nb_next_ff <= nb_next_in;
      nb_prev_ff <= nb_prev_in;
      rval_ff    <= rval_in;
      rstat_ff   <= rstat_in;
      rcount_ff  <= rcount_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_read_value = rval_ff;
   assign rsp_status     = rstat_ff;
   assign rsp_item_count = rcount_ff;

endmodule

[rtl/core/positional_list_engine_core.sv]
`timescale 1ns / 1ps
// Channel    Ports                                         Handshake
// request    req_action, req_position, req_value           start & !busy
// response   rsp_read_value, rsp_status, rsp_item_count    rsp_strobe, one cycle
//
// One request at a time; busy stays high until its response is issued.
// Positional actions walk the next links one entry per cycle.
// The walk rate is set by the registered read of the next-link memory.
// Reset empties the list at once; no memory sweep is needed.
// The response cannot be stalled; it is shown for exactly one cycle.
module positional_list_engine_core import ple_pkg::*; #(
   parameter int CAPACITY   = PLE_CAPACITY,
   parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [POS_W-1:0]  req_position,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_strobe,
   output logic [VAL_W-1:0]  rsp_read_value,
   output logic [STAT_W-1:0] rsp_status,
   output logic [POS_W-1:0]  rsp_item_count
);

   ple_cmd_type  cmd;
   ple_stat_type stat;

   ple_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd));

   ple_dpath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dpath (
      .clock(clock), .reset(reset),
      .req_action(req_action), .req_position(req_position), .req_value(req_value),
      .cmd(cmd), .stat(stat),
      .rsp_strobe(rsp_strobe), .rsp_read_value(rsp_read_value),
      .rsp_status(rsp_status), .rsp_item_count(rsp_item_count));

endmodule

[rtl/core/ple_checker.sv]
`timescale 1ns / 1ps
module ple_checker import ple_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [VAL_W-1:0]  rsp_read_value,
   input logic [STAT_W-1:0] rsp_status
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_done_on_release: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("busy dropped without a response");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_DONE || rsp_status == ST_MISS ||
                      rsp_status == ST_FULL))
      else $error("bad response status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_DONE |-> rsp_read_value == '0)
      else $error("failed request returned data");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_read_value(rsp_read_value),
   .rsp_status(rsp_status));

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import ple_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_REQS = 1450;
   localparam int QUIET_TAIL  = 150;

   // Shadow of the list contents plus the queue of responses still owed.
   class list_scoreboard;
      logic [VAL_W-1:0]  words[$];
      logic [VAL_W-1:0]  owed_value[$];
      logic [STAT_W-1:0] owed_status[$];
      logic [POS_W-1:0]  owed_count[$];
      int                errors = 0;

      function int pending();
         return owed_value.size();
      endfunction

      function int depth();
         return words.size();
      endfunction

      function void note_request(ple_action_type act, logic [POS_W-1:0] pos_in,
                                 logic [VAL_W-1:0] val);
         int                p;
         int                n;
         logic [VAL_W-1:0]  rd;
         logic [STAT_W-1:0] st;
         p  = (pos_in == 0) ? 1 : int'(pos_in);
         n  = words.size();
         rd = '0;
         st = ST_DONE;
         case (act)
            ACT_INS_FRONT: begin
               if (n >= PLE_CAPACITY) st = ST_FULL;
               else words.push_front(val);
            end
            ACT_INS_BACK: begin
               if (n >= PLE_CAPACITY) st = ST_FULL;
               else words.push_back(val);
            end
            ACT_INS_AFTER: begin
               if (n >= PLE_CAPACITY) st = ST_FULL;
               else if (p >= n) words.push_back(val);
               else words.insert(p, val);
            end
            ACT_RM_FRONT: begin
               if (n == 0) st = ST_MISS;
               else void'(words.pop_front());
            end
            ACT_RM_BACK: begin
               if (n == 0) st = ST_MISS;
               else void'(words.pop_back());
            end
            ACT_RM_POS: begin
               if (p > n) st = ST_MISS;
               else words.delete(p - 1);
            end
            ACT_READ: begin
               if (p > n) st = ST_MISS;
               else rd = words[p - 1];
            end
            default: begin
               if (p > n) st = ST_MISS;
               else words[p - 1] = val;
            end
         endcase
         owed_value.push_back(rd);
         owed_status.push_back(st);
         owed_count.push_back(POS_W'(words.size()));
      endfunction

      function void check_response(logic [VAL_W-1:0] rd, logic [STAT_W-1:0] st,
                                   logic [POS_W-1:0] cnt);
         logic [VAL_W-1:0]  e_rd;
         logic [STAT_W-1:0] e_st;
         logic [POS_W-1:0]  e_cnt;
         if (owed_value.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e_rd  = owed_value.pop_front();
         e_st  = owed_status.pop_front();
         e_cnt = owed_count.pop_front();
         if (rd !== e_rd) begin
            $error("read_value: expected %h, actual %h", e_rd, rd);
            errors++;
         end
         if (st !== e_st) begin
            $error("status: expected %0d, actual %0d", e_st, st);
            errors++;
         end
         if (cnt !== e_cnt) begin
            $error("item_count: expected %0d, actual %0d", e_cnt, cnt);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [ACT_W-1:0]  req_action;
   logic [POS_W-1:0]  req_position;
   logic [VAL_W-1:0]  req_value;
   logic              rsp_strobe;
   logic [VAL_W-1:0]  rsp_read_value;
   logic [STAT_W-1:0] rsp_status;
   logic [POS_W-1:0]  rsp_item_count;

   list_scoreboard sb = new();
   int cycles = 0;

   positional_list_engine_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_item_count (rsp_item_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_read_value, rsp_status, rsp_item_count);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Hold the request until the block takes it; start is left high.
   task automatic send_request(ple_action_type act, int pos, logic [VAL_W-1:0] val);
      req_action   <= act;
      req_position <= POS_W'(pos);
      req_value    <= val;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(act, POS_W'(pos), val);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic ple_action_type pick_action(bit growing);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         if (growing) return ple_action_type'($urandom_range(0, 2));
         return ple_action_type'($urandom_range(3, 5));
      end
      return ple_action_type'($urandom_range(0, 7));
   endfunction

   initial begin
      bit growing;
      int pos;
      ple_action_type act;
      reset        = 1'b1;
      start        = 1'b0;
      req_action   = '0;
      req_position = '0;
      req_value    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corners, then small-list inserts, reads, writes and removals
      send_request(ACT_RM_FRONT, 0, 32'h0);
      send_request(ACT_RM_BACK, 0, 32'h0);
      send_request(ACT_RM_POS, 0, 32'h0);
      send_request(ACT_READ, 0, 32'h0);
      send_request(ACT_WRITE, 1, 32'hFFFF_FFFF);
      send_request(ACT_INS_AFTER, 5, 32'hFFFF_FFFF);
      send_request(ACT_INS_FRONT, 0, 32'h0);
      send_request(ACT_INS_BACK, 511, 32'h1234_5678);
      send_request(ACT_INS_AFTER, 1, 32'hA5A5_5A5A);
      send_request(ACT_INS_AFTER, 256, 32'h5A5A_A5A5);
      send_request(ACT_READ, 0, 32'h0);
      send_request(ACT_READ, 4, 32'h0);
      send_request(ACT_READ, 511, 32'h0);
      send_request(ACT_WRITE, 2, 32'hDEAD_BEEF);
      send_request(ACT_WRITE, 5, 32'h0);
      send_request(ACT_READ, 2, 32'h0);
      send_request(ACT_RM_POS, 1, 32'h0);
      send_request(ACT_RM_POS, 3, 32'h0);
      send_request(ACT_RM_POS, 4, 32'h0);
      send_request(ACT_INS_FRONT, 0, 32'h8000_0001);
      send_request(ACT_RM_POS, 2, 32'h0);
      send_request(ACT_RM_BACK, 0, 32'h0);
      send_request(ACT_RM_FRONT, 0, 32'h0);

      // hold off until the block has answered everything
      drain();

      growing = 1'b1;
      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (sb.depth() >= PLE_CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
         if (sb.depth() == 0) growing = 1'b1;
         act = pick_action(growing);
         if ($urandom_range(0, 9) < 7) pos = $urandom_range(0, sb.depth() + 1);
         else pos = $urandom_range(0, 511);
         if (i < RANDOM_REQS - 150 && $urandom_range(0, 5) == 0 && (i / 200) % 2 == 0)
            idle_burst();
         send_request(act, pos, pick_value());
      end

      drain();
      repeat (QUIET_TAIL) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
